>>> src/sca_pkg.sv
// shared types and constants for the sector color averager
// no dependencies
package sca_pkg;

	localparam logic [1:0] ACT_PIXEL  = 2'd0;
	localparam logic [1:0] ACT_RECT   = 2'd1;
	localparam logic [1:0] ACT_FINISH = 2'd2;
	localparam logic [1:0] ACT_NOP    = 2'd3;

	localparam logic [1:0] REG_STRIDE     = 2'd0;
	localparam logic [1:0] REG_BRIGHTNESS = 2'd1;
	localparam logic [1:0] REG_ACTIVE     = 2'd2;

	localparam int SUM_BITS   = 32;
	localparam int COUNT_BITS = 24;

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_SCAN   = 7'b0000010,
		ST_DIVLD  = 7'b0000100,
		ST_DIV    = 7'b0001000,
		ST_EMIT   = 7'b0010000,
		ST_CLEAR  = 7'b0100000,
		ST_PIX    = 7'b1000000
	} state_t;

	// command to the divider
	typedef struct packed {
		logic                start;
		logic [SUM_BITS-1:0] dividend;
		logic [SUM_BITS-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic                busy;
		logic                done;
		logic [SUM_BITS-1:0] quotient;
	} div_rsp_t;

endpackage

>>> src/sector_color_averager_top.sv
// sector color averager top: apb registers, sector store, sequencer
// depends on sca_pkg and sca_div
//
// usage: load sector rectangles with action 1, stream pixels with action 0,
// then send action 2 to get one result per active sector, the last one
// flagged by last. registers are to be written through the apb port while
// the block idles; the block itself does not enforce this. a pixel request
// is checked against one sector at a time by a shared remainder unit: a load
// step and then COORD_BITS remainder steps per sector. a rectangle write is
// stored on acceptance and leaves the block idle. finish runs, per active
// sector, three 32-step divisions on one shared divider and emits the result,
// then clears the accumulators.
// the input stall is high whenever an item is in progress.
// when the receiver stalls the result register holds and the sequencer waits.
// reset clears accumulators, restores register defaults (stride 1, floor 0,
// 16 active) and leaves the rectangles undefined until written.
module sector_color_averager_top #(
	parameter int SECTOR_COUNT = 16,
	parameter int COORD_BITS   = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  action,
	input  logic [11:0] pixel_x,
	input  logic [11:0] pixel_y,
	input  logic [7:0]  red,
	input  logic [7:0]  green,
	input  logic [7:0]  blue,
	input  logic [3:0]  sector_index,
	input  logic [11:0] sector_top,
	input  logic [11:0] sector_bottom,
	input  logic [11:0] sector_left,
	input  logic [11:0] sector_right,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  out_sector,
	output logic [7:0]  red_average,
	output logic [7:0]  green_average,
	output logic [7:0]  blue_average,
	output logic        last
);
	localparam int SW = (SECTOR_COUNT > 1) ? $clog2(SECTOR_COUNT) : 1;
	localparam int NW = $clog2(SECTOR_COUNT + 1);
	localparam int SB = sca_pkg::SUM_BITS;
	localparam int CB = sca_pkg::COUNT_BITS;
	localparam logic [SB-1:0] SUM_MAX   = '1;
	localparam logic [CB-1:0] COUNT_MAX = '1;

	// registers
	logic [7:0] stride_q, floor_q;
	logic [4:0] active_q;
	logic       wr_en;
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stride_q <= 8'd1;
			floor_q  <= 8'd0;
			active_q <= 5'd16;
		end else if (wr_en) begin
			unique case (paddr[3:2])
				sca_pkg::REG_STRIDE:     stride_q <= pwdata[7:0];
				sca_pkg::REG_BRIGHTNESS: floor_q  <= pwdata[7:0];
				sca_pkg::REG_ACTIVE:     active_q <= pwdata[4:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			sca_pkg::REG_STRIDE:     prdata = {24'd0, stride_q};
			sca_pkg::REG_BRIGHTNESS: prdata = {24'd0, floor_q};
			sca_pkg::REG_ACTIVE:     prdata = {27'd0, active_q};
			default:                 prdata = '0;
		endcase
	end

	// sector state, each entry read only at the sequencer index
	logic [COORD_BITS-1:0] top_q [SECTOR_COUNT];
	logic [COORD_BITS-1:0] bot_q [SECTOR_COUNT];
	logic [COORD_BITS-1:0] lft_q [SECTOR_COUNT];
	logic [COORD_BITS-1:0] rgt_q [SECTOR_COUNT];
	logic [SB-1:0] rs_q [SECTOR_COUNT];
	logic [SB-1:0] gs_q [SECTOR_COUNT];
	logic [SB-1:0] bs_q [SECTOR_COUNT];
	logic [CB-1:0] kc_q [SECTOR_COUNT];
	logic [CB-1:0] ic_q [SECTOR_COUNT];

	sca_pkg::state_t state_q;
	logic [SW-1:0] idx_q;
	logic [NW-1:0] n_q;
	logic [1:0]    ch_q;
	logic [COORD_BITS-1:0] px_q, py_q;
	logic [7:0]  r_q, g_q, b_q;
	logic        dark_q;
	logic [7:0]  avg_q [3];
	logic [8:0]  stride_eff;
	logic [9:0]  brightness_sum;
	logic [9:0]  floor3;

	assign stride_eff     = (stride_q == 8'd0) ? 9'd1 : {1'b0, stride_q};
	assign brightness_sum = 10'(red) + 10'(green) + 10'(blue);
	assign floor3         = 10'(floor_q) * 10'd3;

	// shared remainder unit: one restoring step per cycle on both offsets,
	// with the stride shifted down from COORD_BITS-1 to 0
	logic [COORD_BITS-1:0] dy_q, dx_q;
	logic [3:0]            rem_cnt_q;
	logic                  in_y, in_x;
	logic [COORD_BITS-1:0] dy_n, dx_n;

	assign in_y = (py_q >= top_q[idx_q]) && (py_q < bot_q[idx_q]);
	assign in_x = (px_q >= lft_q[idx_q]) && (px_q < rgt_q[idx_q]);

	// one restoring step on both offsets, stride shifted by rem_cnt
	function automatic logic [COORD_BITS-1:0] rstep(
		input logic [COORD_BITS-1:0] v, input logic [8:0] d, input logic [3:0] sh);
		logic [COORD_BITS+8:0] ds;
		ds = {{COORD_BITS{1'b0}}, d} << sh;
		if ({9'd0, v} >= ds) rstep = v - ds[COORD_BITS-1:0];
		else rstep = v;
	endfunction

	assign dy_n = rstep(dy_q, stride_eff, rem_cnt_q);
	assign dx_n = rstep(dx_q, stride_eff, rem_cnt_q);

	logic hit;
	assign hit = in_y && in_x && (dy_n == '0) && (dx_n == '0);

	sca_pkg::div_req_t dreq;
	sca_pkg::div_rsp_t drsp;
	logic [SB-1:0] divisor;
	logic [SB-1:0] dividend;

	assign divisor  = SB'(kc_q[idx_q]) + SB'(ic_q[idx_q] >> 4) + SB'(1);
	always_comb begin
		case (ch_q)
			2'd0:    dividend = rs_q[idx_q];
			2'd1:    dividend = gs_q[idx_q];
			default: dividend = bs_q[idx_q];
		endcase
	end
	assign dreq.start    = (state_q == sca_pkg::ST_DIVLD);
	assign dreq.dividend = dividend;
	assign dreq.divisor  = divisor;

	sca_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	logic accept;
	assign in_stall = (state_q != sca_pkg::ST_IDLE);
	assign accept   = in_valid && !in_stall;

	logic [NW-1:0] act_n;
	assign act_n = (32'(active_q) > SECTOR_COUNT) ? NW'(SECTOR_COUNT) : NW'(active_q);

	logic [3:0] max_sh;
	assign max_sh = 4'(COORD_BITS - 1);

	logic emit_go;
	assign emit_go = (state_q == sca_pkg::ST_EMIT) && (!out_valid || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= sca_pkg::ST_IDLE;
			idx_q     <= '0;
			n_q       <= '0;
			ch_q      <= '0;
			rem_cnt_q <= '0;
			out_valid <= 1'b0;
			for (int i = 0; i < SECTOR_COUNT; i++) begin
				rs_q[i] <= '0; gs_q[i] <= '0; bs_q[i] <= '0;
				kc_q[i] <= '0; ic_q[i] <= '0;
			end
		end else begin
			if (emit_go) out_valid <= 1'b1;
			else if (out_valid && !out_stall) out_valid <= 1'b0;
			unique case (state_q)
				sca_pkg::ST_IDLE: begin
					if (accept) begin
						idx_q <= '0;
						ch_q  <= '0;
						case (action)
							sca_pkg::ACT_PIXEL: state_q <= sca_pkg::ST_PIX;
							sca_pkg::ACT_FINISH: begin
								n_q <= act_n;
								state_q <= (act_n == '0) ? sca_pkg::ST_CLEAR
								                         : sca_pkg::ST_DIVLD;
							end
							default: ;
						endcase
					end
				end
				sca_pkg::ST_PIX: begin
					// load offsets for the current sector
					dy_q      <= py_q - top_q[idx_q];
					dx_q      <= px_q - lft_q[idx_q];
					rem_cnt_q <= max_sh;
					state_q   <= sca_pkg::ST_SCAN;
				end
				sca_pkg::ST_SCAN: begin
					dy_q <= dy_n;
					dx_q <= dx_n;
					if (rem_cnt_q != 4'd0) begin
						rem_cnt_q <= rem_cnt_q - 4'd1;
					end else begin
						if (hit) begin
							if (dark_q) begin
								if (ic_q[idx_q] != COUNT_MAX) ic_q[idx_q] <= ic_q[idx_q] + 1'b1;
							end else begin
								rs_q[idx_q] <= ((SB+1)'(rs_q[idx_q]) + (SB+1)'(r_q) > (SB+1)'(SUM_MAX))
								               ? SUM_MAX : rs_q[idx_q] + SB'(r_q);
								gs_q[idx_q] <= ((SB+1)'(gs_q[idx_q]) + (SB+1)'(g_q) > (SB+1)'(SUM_MAX))
								               ? SUM_MAX : gs_q[idx_q] + SB'(g_q);
								bs_q[idx_q] <= ((SB+1)'(bs_q[idx_q]) + (SB+1)'(b_q) > (SB+1)'(SUM_MAX))
								               ? SUM_MAX : bs_q[idx_q] + SB'(b_q);
								if (kc_q[idx_q] != COUNT_MAX) kc_q[idx_q] <= kc_q[idx_q] + 1'b1;
							end
						end
						if (32'(idx_q) == SECTOR_COUNT - 1) begin
							state_q <= sca_pkg::ST_IDLE;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= sca_pkg::ST_PIX;
						end
					end
				end
				sca_pkg::ST_DIVLD: begin
					state_q <= sca_pkg::ST_DIV;
				end
				sca_pkg::ST_DIV: begin
					if (drsp.done) begin
						avg_q[ch_q] <= (drsp.quotient > 32'd255) ? 8'd255 : drsp.quotient[7:0];
						if (ch_q == 2'd2) begin
							ch_q    <= '0;
							state_q <= sca_pkg::ST_EMIT;
						end else begin
							ch_q    <= ch_q + 2'd1;
							state_q <= sca_pkg::ST_DIVLD;
						end
					end
				end
				sca_pkg::ST_EMIT: begin
					if (emit_go) begin
						out_sector    <= 4'(idx_q);
						red_average   <= avg_q[0];
						green_average <= avg_q[1];
						blue_average  <= avg_q[2];
						last          <= (NW'(idx_q) + NW'(1) == n_q);
						if (NW'(idx_q) + NW'(1) == n_q) begin
							state_q <= sca_pkg::ST_CLEAR;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= sca_pkg::ST_DIVLD;
						end
					end
				end
				sca_pkg::ST_CLEAR: begin
					for (int i = 0; i < SECTOR_COUNT; i++) begin
						rs_q[i] <= '0; gs_q[i] <= '0; bs_q[i] <= '0;
						kc_q[i] <= '0; ic_q[i] <= '0;
					end
					state_q <= sca_pkg::ST_IDLE;
				end
				default: state_q <= sca_pkg::ST_IDLE;
			endcase
		end
	end

	// request capture and rectangle store
	always_ff @(posedge clk) begin
		if (accept) begin
			px_q   <= COORD_BITS'(pixel_x);
			py_q   <= COORD_BITS'(pixel_y);
			r_q    <= red;
			g_q    <= green;
			b_q    <= blue;
			dark_q <= brightness_sum < floor3;
			if (action == sca_pkg::ACT_RECT && 32'(sector_index) < SECTOR_COUNT) begin
				top_q[SW'(sector_index)] <= COORD_BITS'(sector_top);
				bot_q[SW'(sector_index)] <= COORD_BITS'(sector_bottom);
				lft_q[SW'(sector_index)] <= COORD_BITS'(sector_left);
				rgt_q[SW'(sector_index)] <= COORD_BITS'(sector_right);
			end
		end
	end
endmodule

>>> src/sca_div.sv
// shared restoring divider, one quotient bit per cycle
// depends on sca_pkg
module sca_div (
	input  logic              clk,
	input  logic              arst_n,
	input  sca_pkg::div_req_t req,
	output sca_pkg::div_rsp_t rsp
);
	localparam int W = sca_pkg::SUM_BITS;

	logic [W-1:0]         quo_q;
	logic [W-1:0]         rem_q;
	logic [W-1:0]         den_q;
	logic [$clog2(W):0]   cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [W:0]           trial;

	assign trial = {rem_q, quo_q[W-1]} - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= ($clog2(W)+1)'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == ($clog2(W)+1)'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			den_q <= req.divisor;
		end else if (busy_q) begin
			if (!trial[W]) begin
				rem_q <= trial[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[W-2:0], quo_q[W-1]};
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;
endmodule
